[design/assert_macros.svh]
// Assertion macros used by the poll backoff scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent in the same cycle implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent in one cycle implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[design/pbs_pkg.sv]
// Package with types and constants of the poll backoff scheduler.
`default_nettype none

package pbs_pkg;

  // Default width of the internal time base.
  localparam int TIME_BITS_DEFAULT = 32;

  localparam int NOW_BITS      = 32;
  localparam int INTERVAL_BITS = 16;
  localparam int SHIFT_BITS    = 3;
  localparam int FAIL_BITS     = 4;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [FAIL_BITS-1:0] FAIL_MAX = 4'd15;

  // Register values after reset.
  localparam logic [INTERVAL_BITS-1:0] REGULAR_INTERVAL_RST = 16'd30;
  localparam logic [INTERVAL_BITS-1:0] BACKOFF_BASE_RST     = 16'd60;
  localparam logic [INTERVAL_BITS-1:0] BACKOFF_CAP_RST      = 16'd300;
  localparam logic [SHIFT_BITS-1:0]    SHIFT_LIMIT_RST      = 3'd3;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_REQUEST = 2'd1,
    OP_POLL    = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_REGULAR_INTERVAL = 2'd0,
    REG_BACKOFF_BASE     = 2'd1,
    REG_BACKOFF_CAP      = 2'd2,
    REG_SHIFT_LIMIT      = 2'd3
  } cfg_index_t;

  typedef struct packed {
    op_t                 op;
    logic [NOW_BITS-1:0] now;
    logic                success;
  } in_item_t;

  typedef struct packed {
    logic                poll_due;
    logic                deadline_valid;
    logic [NOW_BITS-1:0] next_poll_time;
    logic                armed;
  } out_item_t;

  typedef struct packed {
    logic [INTERVAL_BITS-1:0] regular_interval;
    logic [INTERVAL_BITS-1:0] backoff_base;
    logic [INTERVAL_BITS-1:0] backoff_cap;
    logic [SHIFT_BITS-1:0]    shift_limit;
  } cfg_regs_t;

  // Scheduler flags; the deadline travels separately since its width is a parameter.
  typedef struct packed {
    logic                 armed;
    logic                 deadline_set;
    logic [FAIL_BITS-1:0] failure_count;
  } sched_flags_t;

endpackage

`default_nettype wire

[design/poll_backoff_scheduler_unit.sv]
// Top level of the poll scheduler with capped exponential backoff.
//
//   Channel | Handshake                 | Transaction
//   --------+---------------------------+-------------------------------------
//   in      | in_valid / in_stall       | op, now, success
//   out     | out_valid / out_stall     | poll_due, deadline_valid, time, armed
//   cfg     | cfg_valid / cfg_ready     | register index and write data
//
// One item per cycle sustained while out_stall is low; an input transaction passes
// through the input register, then the result register with the state update,
// and the result then stays valid until it is taken.
// Reset (rst, synchronous) clears the schedule state and loads the register
// defaults. in_stall rises only while the input register holds an item and the
// result register is held by out_stall. cfg_ready is always high.
`default_nettype none
`include "assert_macros.svh"

module poll_backoff_scheduler_unit #(
  parameter int TIME_BITS = pbs_pkg::TIME_BITS_DEFAULT
) (
  input  var logic                                clk,
  input  var logic                                rst,
  input  var logic                                in_valid,
  output logic                                    in_stall,
  input  var pbs_pkg::in_item_t                   in_data,
  output logic                                    out_valid,
  input  var logic                                out_stall,
  output pbs_pkg::out_item_t                      out_data,
  input  var logic                                cfg_valid,
  output logic                                    cfg_ready,
  input  var logic [pbs_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  var logic [pbs_pkg::INTERVAL_BITS-1:0]   cfg_data
);
  import pbs_pkg::*;

  in_item_t             s1_data;
  logic                 s1_valid;
  logic                 s2_load;
  cfg_regs_t            cfg;
  sched_flags_t         flags;
  sched_flags_t         flags_next;
  logic [TIME_BITS-1:0] deadline;
  logic [TIME_BITS-1:0] deadline_next;
  out_item_t            result;
  cfg_index_t           cfg_sel;

  // Handshake: the result register loads when empty or being drained.
  assign s2_load   = !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s2_load;
  assign cfg_ready = 1'b1;
  assign cfg_sel   = cfg_index_t'(cfg_index);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.regular_interval <= REGULAR_INTERVAL_RST;
      cfg.backoff_base     <= BACKOFF_BASE_RST;
      cfg.backoff_cap      <= BACKOFF_CAP_RST;
      cfg.shift_limit      <= SHIFT_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_sel)
        REG_REGULAR_INTERVAL: cfg.regular_interval <= cfg_data;
        REG_BACKOFF_BASE:     cfg.backoff_base     <= cfg_data;
        REG_BACKOFF_CAP:      cfg.backoff_cap      <= cfg_data;
        REG_SHIFT_LIMIT:      cfg.shift_limit      <= cfg_data[SHIFT_BITS-1:0];
        default:              cfg.shift_limit      <= cfg.shift_limit;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  // Per-item update logic.
  pbs_update #(
    .TIME_BITS(TIME_BITS)
  ) u_update (
    .item         (s1_data),
    .cfg          (cfg),
    .flags        (flags),
    .deadline     (deadline),
    .flags_next   (flags_next),
    .deadline_next(deadline_next),
    .result       (result)
  );

  // Schedule state and result register advance together.
  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      deadline  <= '0;
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= s1_valid;
      if (s1_valid) begin
        flags    <= flags_next;
        deadline <= deadline_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load && s1_valid) begin
      out_data <= result;
    end
  end

  // Checks on the scheduling state and the pipeline.
  `ASSERT_SAME(a_due_needs_armed, clk, rst, out_valid && out_data.poll_due,
               out_data.armed && out_data.deadline_valid)
  `ASSERT_SAME(a_armed_has_deadline, clk, rst, flags.armed, flags.deadline_set)
  `ASSERT_SAME(a_unset_deadline_zero, clk, rst, !flags.deadline_set, deadline == '0)
  `ASSERT_NEXT(a_no_extra_result, clk, rst, !s1_valid && (!out_valid || !out_stall),
               !out_valid)

endmodule

`default_nettype wire

[design/pbs_update.sv]
// Next-state and result logic of the poll backoff scheduler for one item.
`default_nettype none

module pbs_update #(
  parameter int TIME_BITS = pbs_pkg::TIME_BITS_DEFAULT
) (
  input  var pbs_pkg::in_item_t     item,
  input  var pbs_pkg::cfg_regs_t    cfg,
  input  var pbs_pkg::sched_flags_t flags,
  input  var logic [TIME_BITS-1:0]  deadline,
  output pbs_pkg::sched_flags_t     flags_next,
  output logic [TIME_BITS-1:0]      deadline_next,
  output pbs_pkg::out_item_t        result
);
  import pbs_pkg::*;

  localparam int SHIFTED_BITS = INTERVAL_BITS + (1 << SHIFT_BITS) - 1;

  logic [TIME_BITS-1:0]     now_t;
  logic [FAIL_BITS-1:0]     fail_inc;
  logic [FAIL_BITS-1:0]     shift_raw;
  logic [SHIFT_BITS-1:0]    shift_amt;
  logic [SHIFTED_BITS-1:0]  shifted;
  logic [INTERVAL_BITS-1:0] backoff;
  logic [TIME_BITS-1:0]     regular_deadline;
  logic [TIME_BITS-1:0]     backoff_deadline;

  // Time is taken modulo the internal time width.
  assign now_t = TIME_BITS'(item.now);

  // Saturating failure count and the capped exponential delay it selects.
  always_comb begin
    fail_inc  = (flags.failure_count < FAIL_MAX) ? flags.failure_count + 1'b1 : FAIL_MAX;
    shift_raw = fail_inc - 1'b1;
    shift_amt = (shift_raw > FAIL_BITS'(cfg.shift_limit)) ? cfg.shift_limit
                                                          : shift_raw[SHIFT_BITS-1:0];
    shifted   = SHIFTED_BITS'(cfg.backoff_base) << shift_amt;
    backoff   = (shifted > SHIFTED_BITS'(cfg.backoff_cap)) ? cfg.backoff_cap
                                                           : shifted[INTERVAL_BITS-1:0];
  end

  assign regular_deadline = now_t + TIME_BITS'(cfg.regular_interval);
  assign backoff_deadline = now_t + TIME_BITS'(backoff);

  // Operation decode.
  always_comb begin
    flags_next    = flags;
    deadline_next = deadline;
    unique case (item.op)
      OP_CLEAR: begin
        flags_next    = '0;
        deadline_next = '0;
      end
      OP_REQUEST: begin
        if (!flags.armed) begin
          flags_next.armed         = 1'b1;
          flags_next.failure_count = '0;
          flags_next.deadline_set  = 1'b1;
          deadline_next            = regular_deadline;
        end
      end
      OP_POLL: begin
        if (flags.armed) begin
          flags_next.deadline_set = 1'b1;
          if (item.success) begin
            flags_next.failure_count = '0;
            deadline_next            = regular_deadline;
          end else begin
            flags_next.failure_count = fail_inc;
            deadline_next            = backoff_deadline;
          end
        end
      end
      OP_QUERY: begin
        flags_next = flags;
      end
      default: begin
        flags_next = flags;
      end
    endcase
  end

  // Report taken after the update.
  always_comb begin
    result.poll_due       = flags_next.armed && flags_next.deadline_set &&
                            (now_t >= deadline_next);
    result.deadline_valid = flags_next.deadline_set;
    result.next_poll_time = flags_next.deadline_set ? NOW_BITS'(deadline_next) : '0;
    result.armed          = flags_next.armed;
  end

endmodule

`default_nettype wire

[dv/pbs_checker.sv]
// Checker for the poll backoff scheduler: tracks the schedule and compares every result.
module pbs_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  pbs_pkg::in_item_t                 in_data,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  pbs_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [pbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [pbs_pkg::INTERVAL_BITS-1:0] cfg_data,
  input  logic                              drained,
  output int                                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pbs_pkg::*;

  // Shadow copy of the registers and of the schedule state.
  cfg_regs_t           regs;
  sched_flags_t        flags;
  logic [NOW_BITS-1:0] deadline_q;

  // Status reports that the block still owes, oldest first.
  out_item_t schedule_reports[$];

  int   errors = 0;
  int   n_checked = 0;
  logic leftovers_seen = 1'b0;

  assign fail_count = errors;

  task automatic report_error(string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic check_field(string name, logic [NOW_BITS-1:0] got,
                             logic [NOW_BITS-1:0] want);
    if (got !== want) begin
      report_error($sformatf("report %0d: %s is 0x%0h, expected 0x%0h",
                             n_checked, name, got, want));
    end
  endtask

  // Applies one transaction to the shadow schedule and returns the status after it.
  function automatic out_item_t advance_schedule(in_item_t item);
    out_item_t                  status;
    logic [SHIFT_BITS:0]        sh;
    logic [INTERVAL_BITS+6:0]   scaled;
    logic [INTERVAL_BITS-1:0]   delay;
    logic                       reschedule;
    delay = regs.regular_interval;
    reschedule = 1'b0;
    case (item.op)
      OP_CLEAR: begin
        flags = '0;
        deadline_q = '0;
      end
      OP_REQUEST: begin
        // Only the first request arms the scheduler; repeats are ignored.
        if (!flags.armed) begin
          flags.armed = 1'b1;
          flags.failure_count = '0;
          reschedule = 1'b1;
        end
      end
      OP_POLL: begin
        if (flags.armed) begin
          reschedule = 1'b1;
          if (item.success) begin
            flags.failure_count = '0;
          end else begin
            // Failures saturate; the shift is bounded by the shift limit.
            if (flags.failure_count != FAIL_MAX) begin
              flags.failure_count = flags.failure_count + 1'b1;
            end
            sh = flags.failure_count - 1'b1;
            if (sh > regs.shift_limit) begin
              sh = regs.shift_limit;
            end
            scaled = {7'b0, regs.backoff_base} << sh;
            delay = (scaled > regs.backoff_cap) ? regs.backoff_cap
                                                : scaled[INTERVAL_BITS-1:0];
          end
        end
      end
      OP_QUERY: begin
      end
    endcase
    if (reschedule) begin
      deadline_q = item.now + delay;
      flags.deadline_set = 1'b1;
    end
    status.poll_due = flags.armed && flags.deadline_set && (item.now >= deadline_q);
    status.deadline_valid = flags.deadline_set;
    status.next_poll_time = flags.deadline_set ? deadline_q : '0;
    status.armed = flags.armed;
    return status;
  endfunction

  // Watch all three channels; outputs are compared before new work is queued.
  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      regs = '{REGULAR_INTERVAL_RST, BACKOFF_BASE_RST, BACKOFF_CAP_RST, SHIFT_LIMIT_RST};
      flags = '0;
      deadline_q = '0;
      schedule_reports.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (schedule_reports.size() == 0) begin
          report_error("result transaction with no input waiting for it");
        end else begin
          want = schedule_reports.pop_front();
          check_field("poll_due", out_data.poll_due, want.poll_due);
          check_field("deadline_valid", out_data.deadline_valid, want.deadline_valid);
          check_field("next_poll_time", out_data.next_poll_time, want.next_poll_time);
          check_field("armed", out_data.armed, want.armed);
        end
        n_checked++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_REGULAR_INTERVAL: regs.regular_interval = cfg_data;
          REG_BACKOFF_BASE:     regs.backoff_base = cfg_data;
          REG_BACKOFF_CAP:      regs.backoff_cap = cfg_data;
          REG_SHIFT_LIMIT:      regs.shift_limit = cfg_data[SHIFT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        schedule_reports = {schedule_reports, advance_schedule(in_data)};
      end
      if (drained && !leftovers_seen) begin
        leftovers_seen = 1'b1;
        if (schedule_reports.size() != 0) begin
          report_error($sformatf("%0d expected results never arrived",
                                 schedule_reports.size()));
        end
      end
    end
  end

endmodule

[dv/tb.sv]
// Testbench top for the poll backoff scheduler: stimulus, idling and the verdict.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pbs_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int PHASES = 9;
  localparam int PHASE_ITEMS = 150;

  logic                     clk;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_valid;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [INTERVAL_BITS-1:0] cfg_data;
  logic                     drained;
  int                       fail_count;

  int unsigned cycles = 0;
  int unsigned n_sent = 0;
  int unsigned n_recv = 0;
  int unsigned n_due = 0;
  int unsigned n_writes = 0;
  logic        calm = 1'b0;
  logic [31:0] t_now = '0;
  int unsigned span = 400;
  int unsigned fail_run = 0;

  poll_backoff_scheduler_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pbs_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .drained    (drained),
    .fail_count (fail_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Cycle count, result count and the run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && out_valid && !out_stall) begin
      n_recv <= n_recv + 1;
      if (out_data.poll_due) begin
        n_due <= n_due + 1;
      end
    end
    if (cycles == LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d of %0d results in", cycles,
               n_recv, n_sent);
      $display("FAILURE");
      $finish;
    end
  end

  // Result side: stall a random number of cycles, then take one transaction.
  initial begin : result_side
    int hold;
    out_stall <= 1'b0;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic in_item_t mk_item(op_t op, logic [31:0] now, logic ok);
    in_item_t item;
    item.op = op;
    item.now = now;
    item.success = ok;
    return item;
  endfunction

  // Mostly an advancing clock with poll outcomes, plus requests, queries, clears and time jumps.
  function automatic in_item_t random_item();
    in_item_t    item;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    item.success = 1'($urandom_range(0, 1));
    if (pick < 3) begin
      item.op = OP_CLEAR;
    end else if (pick < 10) begin
      item.op = OP_REQUEST;
    end else if (pick < 80) begin
      item.op = OP_POLL;
      // Failures come in runs long enough to reach the largest shift limit.
      if (fail_run > 0) begin
        item.success = 1'b0;
        fail_run--;
      end else if ($urandom_range(0, 19) == 0) begin
        fail_run = $urandom_range(8, 20);
      end
    end else begin
      item.op = OP_QUERY;
    end
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      item.now = $urandom;
    end else begin
      if (pick < 6) begin
        t_now = $urandom;
      end else if (pick < 8) begin
        t_now = 32'hFFFF_FFFF - $urandom_range(0, 70000);
      end else begin
        t_now = t_now + $urandom_range(0, span);
      end
      item.now = t_now;
    end
    return item;
  endfunction

  task automatic send_item(in_item_t item);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    n_sent++;
  endtask

  // Drops valid and waits until every result of the phase has come back.
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (n_recv != n_sent);
  endtask

  // Writes all four registers for one phase: extremes and the reset values first, then random values.
  task automatic apply_setting(int phase);
    logic [INTERVAL_BITS-1:0] v [4];
    cfg_index_t               idx;
    int                       i;
    case (phase)
      0: v = '{16'd1, 16'd1, 16'd1, 16'd0};
      1: v = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd7};
      // Zero intervals; the upper shift bits are dropped by the register.
      2: v = '{16'd0, 16'd0, 16'd0, 16'hFFF8};
      // Small base under an open cap doubles all the way to the shift limit.
      3: v = '{16'd5, 16'd1, 16'hFFFF, 16'd7};
      4: v = '{REGULAR_INTERVAL_RST, BACKOFF_BASE_RST, BACKOFF_CAP_RST, 16'(SHIFT_LIMIT_RST)};
      default: begin
        for (i = 0; i < 4; i++) begin
          v[i] = $urandom_range(0, 1) ? 16'($urandom_range(0, 400))
                                      : 16'($urandom_range(0, 65535));
        end
      end
    endcase
    idx = idx.first();
    repeat (4) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data <= v[idx];
      do @(posedge clk); while (!cfg_ready);
      n_writes++;
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
    // Time steps scale with the longest delay so polls land both early and late.
    span = (v[0] > v[2]) ? v[0] : v[2];
    span = span + span / 2 + 8;
  endtask

  initial begin : stimulus
    int k;
    int phase;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_REGULAR_INTERVAL;
    cfg_data <= '0;
    drained <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence with the reset register values.
    send_item(mk_item(OP_QUERY, 32'd0, 1'b0));
    send_item(mk_item(OP_POLL, 32'd5, 1'b0));
    send_item(mk_item(OP_REQUEST, 32'd100, 1'b1));
    send_item(mk_item(OP_REQUEST, 32'd110, 1'b0));
    send_item(mk_item(OP_QUERY, 32'd129, 1'b1));
    send_item(mk_item(OP_QUERY, 32'd130, 1'b0));
    for (k = 0; k < 16; k++) begin
      send_item(mk_item(OP_POLL, 32'd200 + 32'(k) * 10, 1'b0));
    end
    send_item(mk_item(OP_POLL, 32'd400, 1'b1));
    send_item(mk_item(OP_CLEAR, 32'd401, 1'b1));
    // The deadline of this request wraps past the top of the time range.
    send_item(mk_item(OP_REQUEST, 32'hFFFF_FFF0, 1'b0));
    send_item(mk_item(OP_QUERY, 32'hFFFF_FFFF, 1'b1));
    wait_idle();

    // Random phases, each under its own register setting.
    for (phase = 0; phase < PHASES; phase++) begin
      apply_setting(phase);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 50 == 0) begin
          calm = ($urandom_range(0, 3) == 0);
        end
        send_item(random_item());
      end
      wait_idle();
    end

    calm = 1'b0;
    repeat (8) @(posedge clk);
    drained <= 1'b1;
    repeat (2) @(posedge clk);
    $display("Covered %0d input transactions and %0d checked results (%0d due),",
             n_sent, n_recv, n_due);
    $display("under %0d register settings made of %0d register writes.", PHASES + 1,
             n_writes);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[poll_backoff_scheduler_unit.f]
+incdir+design
design/pbs_pkg.sv
design/pbs_update.sv
design/poll_backoff_scheduler_unit.sv
dv/pbs_checker.sv
dv/tb.sv
